/* rtl/core/spc_pkg.sv */
// Shared types and constants for the sphere contact time block.
package spc_pkg;

  typedef enum logic [2:0] {
    OUT_SAME        = 3'd0,
    OUT_OVERLAP     = 3'd1,
    OUT_NO_APPROACH = 3'd2,
    OUT_NO_ROOT     = 3'd3,
    OUT_CONTACT     = 3'd4
  } outcome_e;

  localparam int unsigned IdW   = 10;
  localparam int unsigned CrdW  = 32;
  localparam int unsigned RadW  = 24;
  localparam int unsigned TimeW = 48;

  localparam logic [TimeW-1:0] MinStep = 48'd655;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    outcome_e         outcome;
    logic [TimeW-1:0] now;
  } meta_t;

endpackage

/* rtl/core/sphere_contact_time.sv */
// Pipelined time of first contact of two moving spheres, Q16.16 fixed point.
//
//  channel | signals                                   | dir | carries
//  --------+-------------------------------------------+-----+---------------------------
//  cfg     | cfg_valid_i cfg_ready_o self_id_i         | in  | own unit identifier
//  in      | in_valid_i in_ready_o other_id_i pos_* ...| in  | one sphere pair request
//  out     | out_valid_o out_ready_i outcome_o ...     | out | outcome and contact time
//
// One request enters per cycle while the pipeline is not held; each result passes
// through the 64 one-bit square root stages and 80 one-bit divider stages before it appears.
// The whole pipeline advances while the output register is empty or being taken,
// and holds as one otherwise; valid bits travel with each stage.
// Reset clears every valid bit and self_id; payload registers are not reset.
module sphere_contact_time
  import spc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IdW-1:0]         self_id_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [IdW-1:0]         other_id_i,
  input  logic signed [CrdW-1:0] pos_dx_i,
  input  logic signed [CrdW-1:0] pos_dy_i,
  input  logic signed [CrdW-1:0] pos_dz_i,
  input  logic signed [CrdW-1:0] vel_dx_i,
  input  logic signed [CrdW-1:0] vel_dy_i,
  input  logic signed [CrdW-1:0] vel_dz_i,
  input  logic [RadW-1:0]        radius_own_i,
  input  logic [RadW-1:0]        radius_other_i,
  input  logic [TimeW-1:0]       now_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             outcome_o,
  output logic [TimeW-1:0]       contact_time_o
);

  localparam int unsigned SqSteps  = 64;
  localparam int unsigned DivSteps = 80;

  logic [IdW-1:0] self_id_q;
  logic           en;
  logic           out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q <= '0;
    end else if (cfg_valid_i) begin
      self_id_q <= self_id_i;
    end
  end

  // Stage 1: take magnitudes and signs, add radii, compare identifiers.
  logic        v1_q, same1_q;
  logic [31:0] pm1_q [3];
  logic [31:0] vm1_q [3];
  logic        ng1_q [3];
  logic [24:0] rs1_q;
  logic [TimeW-1:0] now1_q;
  logic signed [CrdW-1:0] pin [3];
  logic signed [CrdW-1:0] vin [3];

  assign pin[0] = pos_dx_i;
  assign pin[1] = pos_dy_i;
  assign pin[2] = pos_dz_i;
  assign vin[0] = vel_dx_i;
  assign vin[1] = vel_dy_i;
  assign vin[2] = vel_dz_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      same1_q <= (other_id_i == self_id_q);
      rs1_q   <= {1'b0, radius_own_i} + {1'b0, radius_other_i};
      now1_q  <= now_i;
      for (int i = 0; i < 3; i++) begin
        pm1_q[i] <= pin[i][CrdW-1] ? 32'(-pin[i]) : 32'(pin[i]);
        vm1_q[i] <= vin[i][CrdW-1] ? 32'(-vin[i]) : 32'(vin[i]);
        ng1_q[i] <= pin[i][CrdW-1] ^ vin[i][CrdW-1];
      end
    end
  end

  // Stage 2: products.
  logic        v2_q, same2_q;
  logic [63:0] pp2_q [3];
  logic [63:0] vv2_q [3];
  logic [63:0] pv2_q [3];
  logic        ng2_q [3];
  logic [49:0] rr2_q;
  logic [TimeW-1:0] now2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      same2_q <= same1_q;
      rr2_q   <= rs1_q * rs1_q;
      now2_q  <= now1_q;
      for (int i = 0; i < 3; i++) begin
        pp2_q[i] <= pm1_q[i] * pm1_q[i];
        vv2_q[i] <= vm1_q[i] * vm1_q[i];
        pv2_q[i] <= pm1_q[i] * vm1_q[i];
        ng2_q[i] <= ng1_q[i];
      end
    end
  end

  // Stage 3: dot product sums, split by sign of each term.
  logic        v3_q, same3_q;
  logic [63:0] pp3_q, vv3_q, bpos3_q, bneg3_q;
  logic [49:0] rr3_q;
  logic [TimeW-1:0] now3_q;
  logic [63:0] bp_d, bn_d;

  always_comb begin
    bp_d = '0;
    bn_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (ng2_q[i]) bn_d = bn_d + pv2_q[i];
      else          bp_d = bp_d + pv2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      same3_q <= same2_q;
      pp3_q   <= pp2_q[0] + pp2_q[1] + pp2_q[2];
      vv3_q   <= vv2_q[0] + vv2_q[1] + vv2_q[2];
      bpos3_q <= bp_d;
      bneg3_q <= bn_d;
      rr3_q   <= rr2_q;
      now3_q  <= now2_q;
    end
  end

  // Stage 4: early outcomes, c and -b.
  logic        v4_q;
  meta_t       m4_q;
  logic [63:0] c4_q, bm4_q, vv4_q;
  outcome_e    oc4_d;

  always_comb begin
    if (same3_q)                    oc4_d = OUT_SAME;
    else if (pp3_q < 64'(rr3_q))    oc4_d = OUT_OVERLAP;
    else if (bpos3_q >= bneg3_q)    oc4_d = OUT_NO_APPROACH;
    else                            oc4_d = OUT_CONTACT;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q.outcome <= oc4_d;
      m4_q.now     <= now3_q;
      c4_q         <= pp3_q - 64'(rr3_q);
      bm4_q        <= bneg3_q - bpos3_q;
      vv4_q        <= vv3_q;
    end
  end

  // Stage 5: 32x32 partial products of b*b and a*c.
  logic        v5_q;
  meta_t       m5_q;
  logic [63:0] c5_q, bm5_q;
  logic [63:0] bll_q, blh_q, bhh_q, rll_q, rlh_q, rhl_q, rhh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_q  <= m4_q;
      c5_q  <= c4_q;
      bm5_q <= bm4_q;
      bll_q <= bm4_q[31:0]  * bm4_q[31:0];
      blh_q <= bm4_q[31:0]  * bm4_q[63:32];
      bhh_q <= bm4_q[63:32] * bm4_q[63:32];
      rll_q <= vv4_q[31:0]  * c4_q[31:0];
      rlh_q <= vv4_q[31:0]  * c4_q[63:32];
      rhl_q <= vv4_q[63:32] * c4_q[31:0];
      rhh_q <= vv4_q[63:32] * c4_q[63:32];
    end
  end

  // Stage 6: assemble the 128-bit products.
  logic         v6_q;
  meta_t        m6_q;
  logic [63:0]  c6_q, bm6_q;
  logic [127:0] lhs6_q, rhs6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m6_q   <= m5_q;
      c6_q   <= c5_q;
      bm6_q  <= bm5_q;
      lhs6_q <= {bhh_q, 64'd0} + {31'd0, blh_q, 33'd0} + {64'd0, bll_q};
      rhs6_q <= {rhh_q, 64'd0} + {32'd0, rlh_q, 32'd0} + {32'd0, rhl_q, 32'd0}
                + {64'd0, rll_q};
    end
  end

  // Square root pipeline; entry 0 is stage 7 (discriminant and root check).
  logic         sq_v_q    [SqSteps+1];
  meta_t        sq_m_q    [SqSteps+1];
  logic [63:0]  sq_c_q    [SqSteps+1];
  logic [63:0]  sq_bm_q   [SqSteps+1];
  logic [127:0] sq_d_q    [SqSteps+1];
  logic [66:0]  sq_rem_q  [SqSteps+1];
  logic [63:0]  sq_root_q [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_m_q[0].now     <= m6_q.now;
      sq_m_q[0].outcome <= (m6_q.outcome == OUT_CONTACT && lhs6_q < rhs6_q) ?
                           OUT_NO_ROOT : m6_q.outcome;
      sq_c_q[0]    <= c6_q;
      sq_bm_q[0]   <= bm6_q;
      sq_d_q[0]    <= lhs6_q - rhs6_q;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [66:0] trial, shifted;
    assign shifted = {sq_rem_q[k][64:0], sq_d_q[k][127-2*k -: 2]};
    assign trial   = {1'b0, sq_root_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_m_q[k+1]  <= sq_m_q[k];
        sq_c_q[k+1]  <= sq_c_q[k];
        sq_bm_q[k+1] <= sq_bm_q[k];
        sq_d_q[k+1]  <= sq_d_q[k];
        if (shifted >= trial) begin
          sq_rem_q[k+1]  <= shifted - trial;
          sq_root_q[k+1] <= {sq_root_q[k][62:0], 1'b1};
        end else begin
          sq_rem_q[k+1]  <= shifted;
          sq_root_q[k+1] <= {sq_root_q[k][62:0], 1'b0};
        end
      end
    end
  end

  // Divider pipeline: floor(c * 2^16 / (-b + s)); entry 0 forms the divisor.
  logic        dv_v_q   [DivSteps+1];
  meta_t       dv_m_q   [DivSteps+1];
  logic [79:0] dv_num_q [DivSteps+1];
  logic [64:0] dv_den_q [DivSteps+1];
  logic [64:0] dv_rem_q [DivSteps+1];
  logic [79:0] dv_q_q   [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_m_q[0]   <= sq_m_q[SqSteps];
      dv_num_q[0] <= {sq_c_q[SqSteps], 16'd0};
      dv_den_q[0] <= {1'b0, sq_bm_q[SqSteps]} + {1'b0, sq_root_q[SqSteps]};
      dv_rem_q[0] <= '0;
      dv_q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [65:0] shifted;
    assign shifted = {dv_rem_q[j], dv_num_q[j][79-j]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_m_q[j+1]   <= dv_m_q[j];
        dv_num_q[j+1] <= dv_num_q[j];
        dv_den_q[j+1] <= dv_den_q[j];
        if (shifted >= {1'b0, dv_den_q[j]}) begin
          dv_rem_q[j+1] <= 65'(shifted - {1'b0, dv_den_q[j]});
          dv_q_q[j+1]   <= {dv_q_q[j][78:0], 1'b1};
        end else begin
          dv_rem_q[j+1] <= shifted[64:0];
          dv_q_q[j+1]   <= {dv_q_q[j][78:0], 1'b0};
        end
      end
    end
  end

  // Clamp the step: saturate to 48 bits, raise to the minimum step.
  logic             fv_q;
  meta_t            fm_q;
  logic [TimeW-1:0] fstep_q;
  logic [TimeW-1:0] step_d;

  always_comb begin
    if (dv_q_q[DivSteps][79:48] != '0) step_d = TimeMax;
    else                               step_d = dv_q_q[DivSteps][47:0];
    if (step_d < MinStep) step_d = MinStep;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fm_q    <= dv_m_q[DivSteps];
      fstep_q <= step_d;
    end
  end

  // Output register: a contact adds the step to now and saturates; an overlap gives now, others zero.
  outcome_e         oc_q;
  logic [TimeW-1:0] time_q;
  logic [TimeW:0]   sum_d;

  assign sum_d = {1'b0, fm_q.now} + {1'b0, fstep_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_q <= fm_q.outcome;
      case (fm_q.outcome)
        OUT_OVERLAP: time_q <= fm_q.now;
        OUT_CONTACT: time_q <= sum_d[TimeW] ? TimeMax : sum_d[TimeW-1:0];
        default:     time_q <= '0;
      endcase
    end
  end

  // Valid bits: advance together with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; fv_q <= 1'b0; out_valid_q <= 1'b0;
      for (int i = 0; i <= SqSteps; i++)  sq_v_q[i] <= 1'b0;
      for (int i = 0; i <= DivSteps; i++) dv_v_q[i] <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      sq_v_q[0] <= v6_q;
      for (int i = 0; i < SqSteps; i++)  sq_v_q[i+1] <= sq_v_q[i];
      dv_v_q[0] <= sq_v_q[SqSteps];
      for (int i = 0; i < DivSteps; i++) dv_v_q[i+1] <= dv_v_q[i];
      fv_q        <= dv_v_q[DivSteps];
      out_valid_q <= fv_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = oc_q;
  assign contact_time_o = time_q;

endmodule

/* test/sphere_contact_time_tb.sv */
// Self-checking testbench for the sphere contact time block.
`timescale 1ns / 1ps

module sphere_contact_time_tb
  import spc_pkg::*;
();

  localparam int unsigned Latency   = 154;
  localparam int unsigned DogLimit  = 5000;
  localparam int unsigned HoldLen   = 600;
  localparam int unsigned RandItems = 376;

  // One sphere pair request as the sender sees it.
  typedef struct {
    logic [IdW-1:0]         other_id;
    logic signed [CrdW-1:0] pos [3];
    logic signed [CrdW-1:0] vel [3];
    logic [RadW-1:0]        r_own;
    logic [RadW-1:0]        r_other;
    logic [TimeW-1:0]       now;
  } pair_req_t;

  typedef struct {
    outcome_e         outcome;
    logic [TimeW-1:0] when;
  } contact_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IdW-1:0] cfg_id = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IdW-1:0] other_id = '0;
  logic signed [CrdW-1:0] pdx = '0, pdy = '0, pdz = '0;
  logic signed [CrdW-1:0] vdx = '0, vdy = '0, vdz = '0;
  logic [RadW-1:0] r_own = '0, r_oth = '0;
  logic [TimeW-1:0] now_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] outcome;
  logic [TimeW-1:0] contact_time;

  logic [IdW-1:0] own_id = '0;      // shadow of the self_id register
  contact_res_t   contact_q[$];     // expected results, oldest first
  int unsigned    mismatches = 0;
  int unsigned    results_seen = 0;
  int unsigned    sent = 0;
  int unsigned    outcome_hits [5];
  bit             calm = 1'b0;      // no random idling on either side while set
  int unsigned    hold_req = 0;     // bumped to ask the receiver for a long hold-off

  always #5 clk = ~clk;

  sphere_contact_time u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .self_id_i      (cfg_id),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .other_id_i     (other_id),
    .pos_dx_i       (pdx),
    .pos_dy_i       (pdy),
    .pos_dz_i       (pdz),
    .vel_dx_i       (vdx),
    .vel_dy_i       (vdy),
    .vel_dz_i       (vdz),
    .radius_own_i   (r_own),
    .radius_other_i (r_oth),
    .now_i          (now_v),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .outcome_o      (outcome),
    .contact_time_o (contact_time)
  );

  // Magnitude of a two's complement coordinate; -2^31 maps to 2^31.
  function automatic logic [63:0] coord_mag(logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (~v + 32'd1) : v;
    return {32'd0, m};
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] d);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= d) r = cand;
    end
    return r;
  endfunction

  // Work out the outcome and time of first contact for one pair.
  function automatic contact_res_t contact_predict(pair_req_t rq, logic [IdW-1:0] sid);
    contact_res_t res;
    logic [63:0]  pp, vv, bpos, bneg, p, v, rr, c, bm, s;
    logic [24:0]  rsum;
    logic [127:0] lhs, rhs;
    logic [191:0] q;
    logic [TimeW:0] t;
    res.outcome = OUT_SAME;
    res.when = '0;
    pp = '0; vv = '0; bpos = '0; bneg = '0;
    if (rq.other_id == sid) return res;
    for (int i = 0; i < 3; i++) begin
      p = coord_mag(rq.pos[i]);
      v = coord_mag(rq.vel[i]);
      pp += p * p;
      vv += v * v;
      if (rq.pos[i][31] != rq.vel[i][31]) bneg += p * v;
      else bpos += p * v;
    end
    rsum = {1'b0, rq.r_own} + {1'b0, rq.r_other};
    rr = {39'd0, rsum} * {39'd0, rsum};
    if (pp < rr) begin
      res.outcome = OUT_OVERLAP;
      res.when = rq.now;
      return res;
    end
    c = pp - rr;
    if (bpos >= bneg) begin
      res.outcome = OUT_NO_APPROACH;
      return res;
    end
    bm = bneg - bpos;
    lhs = {64'd0, bm} * {64'd0, bm};
    rhs = {64'd0, vv} * {64'd0, c};
    if (lhs < rhs) begin
      res.outcome = OUT_NO_ROOT;
      return res;
    end
    s = isqrt128(lhs - rhs);
    q = ({128'd0, c} << 16) / ({128'd0, bm} + {128'd0, s});
    t = (q > {144'd0, TimeMax}) ? {1'b0, TimeMax} : {1'b0, q[TimeW-1:0]};
    if (t < {1'b0, MinStep}) t = {1'b0, MinStep};
    t = t + {1'b0, rq.now};
    if (t > {1'b0, TimeMax}) t = {1'b0, TimeMax};
    res.outcome = OUT_CONTACT;
    res.when = t[TimeW-1:0];
    return res;
  endfunction

  // Offer one request, idling at random beforehand; predict on acceptance.
  task automatic send_pair(pair_req_t rq);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    other_id <= rq.other_id;
    pdx <= rq.pos[0]; pdy <= rq.pos[1]; pdz <= rq.pos[2];
    vdx <= rq.vel[0]; vdy <= rq.vel[1]; vdz <= rq.vel[2];
    r_own <= rq.r_own; r_oth <= rq.r_other; now_v <= rq.now;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    contact_q.push_back(contact_predict(rq, own_id));
    sent++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  task automatic test_write_self_id(logic [IdW-1:0] id);
    drain_all();
    cfg_id <= id;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_id = id;
  endtask

  function automatic pair_req_t make_pair(logic [IdW-1:0] oid,
      int px, int py, int pz, int vx, int vy, int vz,
      logic [RadW-1:0] ro, logic [RadW-1:0] rt, logic [TimeW-1:0] tn);
    pair_req_t rq;
    rq.other_id = oid;
    rq.pos[0] = px; rq.pos[1] = py; rq.pos[2] = pz;
    rq.vel[0] = vx; rq.vel[1] = vy; rq.vel[2] = vz;
    rq.r_own = ro; rq.r_other = rt; rq.now = tn;
    return rq;
  endfunction

  // Random request; most are aimed roughly head-on so they reach the root path.
  function automatic pair_req_t rand_pair();
    pair_req_t rq;
    int unsigned mode;
    int unsigned sh;
    mode = $urandom_range(99);
    rq.other_id = ($urandom_range(19) == 0) ? own_id : IdW'($urandom);
    rq.r_own = RadW'($urandom) >> $urandom_range(0, 23);
    rq.r_other = RadW'($urandom) >> $urandom_range(0, 23);
    rq.now = {16'($urandom), 32'($urandom)};
    if ($urandom_range(9) == 0) rq.now = TimeMax - TimeW'($urandom_range(0, 70000));
    for (int i = 0; i < 3; i++) begin
      if (mode < 30) begin
        rq.pos[i] = $urandom;
        rq.vel[i] = $urandom;
      end else begin
        sh = $urandom_range(0, 24);
        rq.pos[i] = $signed($urandom) >>> sh;
        rq.vel[i] = -(rq.pos[i] >>> $urandom_range(0, 12))
                    + ($signed($urandom) >>> $urandom_range(10, 31));
      end
    end
    return rq;
  endfunction

  task automatic test_directed();
    logic [TimeW-1:0] tn;
    calm = 1'b0;
    tn = 48'h0000_0010_0000;
    // same unit as the block
    send_pair(make_pair(own_id, 65536, 0, 0, -65536, 0, 0, 24'd0, 24'd0, tn));
    // overlapping spheres report the current time
    send_pair(make_pair(10'd5, 65536, 0, 0, 0, 0, 0, 24'h020000, 24'h0, tn));
    // touching exactly is no overlap; contact with the minimum step
    send_pair(make_pair(10'd6, 131072, 0, 0, -65536, 0, 0, 24'h010000, 24'h010000, tn));
    // standing still and receding
    send_pair(make_pair(10'd7, 655360, 0, 0, 0, 0, 0, 24'h0, 24'h0, tn));
    send_pair(make_pair(10'd8, 655360, 0, 0, 65536, 0, 0, 24'h010000, 24'h0, tn));
    // moving at right angles: no approach
    send_pair(make_pair(10'd9, 655360, 0, 0, 0, 65536, 0, 24'h010000, 24'h0, tn));
    // approaching but passing wide: no real root
    send_pair(make_pair(10'd10, 655360, 655360, 0, -65536, 0, 0, 24'h008000, 0, tn));
    // ordinary head-on contact
    send_pair(make_pair(10'd11, 655360, 0, 0, -65536, 0, 0, 24'h010000, 24'h010000, tn));
    send_pair(make_pair(10'd12, -327680, 196608, 65536, 131072, -65536, 0,
                        24'h008000, 24'h004000, tn));
    // very slow approach from far away: large step, then saturation at the top
    send_pair(make_pair(10'd13, 32'h7fffffff, 0, 0, -1, 0, 0, 0, 0, tn));
    send_pair(make_pair(10'd14, 32'h7fffffff, 0, 0, -1, 0, 0, 0, 0, TimeMax));
    send_pair(make_pair(10'd15, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        -1, -1, -1, 0, 0, TimeMax - 48'd10));
    // extreme coordinates (most negative in the first two), largest radii in the first
    send_pair(make_pair(10'd16, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        24'hffffff, 24'hffffff, 48'd0));
    send_pair(make_pair(10'd17, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 48'd0));
    send_pair(make_pair(10'd18, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 48'd1));
    // fast approach from close by: step raised to the floor
    send_pair(make_pair(10'd19, 65537, 0, 0, 32'h80000000, 0, 0, 24'h008000,
                        24'h008000, tn));
    send_pair(make_pair(10'd1023, 0, 0, 0, 0, 0, 0, 0, 0, TimeMax));
    send_pair(make_pair(10'd0, 100, 0, 0, -100, 0, 0, 0, 0, 48'd0));
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      // a stretch without random idling in the middle of each batch
      calm = (k >= n / 3) && (k < n / 2);
      send_pair(rand_pair());
    end
    calm = 1'b0;
  endtask

  // Stall the receiver for a long time while requests keep coming, so the pipe fills.
  task automatic test_backpressure();
    calm = 1'b1;
    hold_req++;
    for (int unsigned k = 0; k < Latency + 40; k++) send_pair(rand_pair());
    calm = 1'b0;
  endtask

  // Sender pauses until every result is back, then resumes.
  task automatic test_drain_pause();
    test_random(20);
    in_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    test_random(20);
  endtask

  // Receiver: random ready, with a long hold-off whenever one is asked for.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    contact_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (contact_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: outcome %0d time %h",
                                       outcome, contact_time);
      end else begin
        exp_res = contact_q.pop_front();
        if (exp_res.outcome <= OUT_CONTACT) outcome_hits[exp_res.outcome]++;
        if (outcome !== exp_res.outcome || contact_time !== exp_res.when) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: outcome exp %0d got %0d, time exp %h got %h",
                     results_seen, exp_res.outcome, outcome, exp_res.when, contact_time);
        end
      end
    end
  end

  // Watchdog: give up when nothing has moved for too long.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > DogLimit) begin
      $display("watchdog expired with %0d results outstanding", contact_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(RandItems / 4);
    test_write_self_id(10'd1023);
    test_directed();
    test_random(RandItems / 4);
    test_backpressure();
    test_write_self_id(IdW'($urandom));
    test_drain_pause();
    test_random(RandItems / 8);
    test_write_self_id(10'd0);
    test_random(RandItems / 8);
    drain_all();
    $display("sent %0d requests over four self_id settings with stalls on both sides",
             sent);
    $display("outcomes seen: same %0d overlap %0d recede %0d miss %0d contact %0d",
             outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
             outcome_hits[4]);
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sphere_contact_time.f */
rtl/core/spc_pkg.sv
rtl/core/sphere_contact_time.sv
test/sphere_contact_time_tb.sv
